FILE: rtl/core/tdsu_pkg.sv
// Shared types and constants for the tick-driven soft UART core.
`timescale 1ns / 1ps
`default_nettype none

package tdsu_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned BITCNT_W = 4;

  // Default frame size, handed to the top level
  localparam int unsigned DATA_BITS_DEFAULT = 8;

  // Bit period after reset
  localparam logic [TICK_W-1:0] TICKS_PER_BIT_RESET = 8'd1;

  // Item command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  // Transmit phase, one-hot
  typedef enum logic [3:0] {
    TX_IDLE  = 4'b0001,
    TX_START = 4'b0010,
    TX_DATA  = 4'b0100,
    TX_STOP  = 4'b1000
  } tx_phase_e;

  // One result item
  typedef struct packed {
    logic              tx_level;
    logic              tx_idle;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } result_t;

endpackage : tdsu_pkg

`default_nettype wire

FILE: rtl/core/tdsu_in_if.sv
// Input item channel: a timer tick with line sample, or a send request.
`timescale 1ns / 1ps
`default_nettype none

interface tdsu_in_if
  import tdsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              rx_level;
  logic [BYTE_W-1:0] send_byte;

  modport source (output valid, output cmd, output rx_level, output send_byte, input ready);
  modport sink   (input valid, input cmd, input rx_level, input send_byte, output ready);
endinterface : tdsu_in_if

`default_nettype wire

FILE: rtl/core/tdsu_out_if.sv
// Result item channel: transmit line state and received byte.
`timescale 1ns / 1ps
`default_nettype none

interface tdsu_out_if
  import tdsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              tx_level;
  logic              tx_idle;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output tx_level, output tx_idle, output rx_valid,
                  output rx_byte, input ready);
  modport sink   (input valid, input tx_level, input tx_idle, input rx_valid,
                  input rx_byte, output ready);
endinterface : tdsu_out_if

`default_nettype wire

FILE: rtl/core/tdsu_cfg_if.sv
// Configuration write channel carrying the bit period register.
`timescale 1ns / 1ps
`default_nettype none

interface tdsu_cfg_if
  import tdsu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : tdsu_cfg_if

`default_nettype wire

FILE: rtl/core/tick_driven_soft_uart_core.sv
// Tick-driven soft UART core: receiver, transmitter and output skid stage.
// Each result is registered in the output register before it appears on the output.
// Throughput: one item per cycle; all state updates in one pass of short logic.
// A stalled output parks one further result in a skid register; input ready
// drops only while that skid register is full.
// Reset (rst_ni low, asynchronous): receiver waiting, transmitter idle with the
// line high, bit period 1, both output stages empty.
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_soft_uart_core
  import tdsu_pkg::*;
#(
  parameter int unsigned DATA_BITS = DATA_BITS_DEFAULT
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  tdsu_in_if.sink      in_i,
  tdsu_out_if.source   out_o,
  tdsu_cfg_if.sink     cfg_i
);

  localparam logic [BITCNT_W-1:0] DataBitsCnt = BITCNT_W'(DATA_BITS);

  // Saturating tick counter increment
  function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] c);
    return (c != {TICK_W{1'b1}}) ? c + TICK_W'(1) : c;
  endfunction

  // Configuration
  logic [TICK_W-1:0] tpb_q;

  // Receiver state
  logic                 rx_busy_q,  rx_busy_d;
  logic [DATA_BITS-1:0] rx_shift_q, rx_shift_d;
  logic [BITCNT_W-1:0]  rx_bit_q,   rx_bit_d;
  logic [TICK_W-1:0]    rx_tick_q,  rx_tick_d;

  // Transmitter state
  tx_phase_e            tx_phase_q, tx_phase_d;
  logic [BYTE_W-1:0]    tx_shift_q, tx_shift_d;
  logic [BITCNT_W-1:0]  tx_bit_q,   tx_bit_d;
  logic [TICK_W-1:0]    tx_tick_q,  tx_tick_d;
  logic                 tx_line_q,  tx_line_d;

  // Output and skid stages
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  logic                        accept;
  logic                        rx_done;
  logic [TICK_W-1:0]           rx_tick_inc;
  logic [TICK_W-1:0]           tx_tick_inc;
  logic [BITCNT_W-1:0]         rx_bit_inc;
  logic [BYTE_W+DATA_BITS-1:0] rx_ext;
  result_t                     res;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !skid_vld_q;
  assign cfg_i.ready = 1'b1;

  // Bit period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= TICKS_PER_BIT_RESET;
    end else if (cfg_i.valid) begin
      tpb_q <= cfg_i.data;
    end
  end

  // Next state of receiver and transmitter for the transferred item
  always_comb begin
    rx_busy_d   = rx_busy_q;
    rx_shift_d  = rx_shift_q;
    rx_bit_d    = rx_bit_q;
    rx_tick_d   = rx_tick_q;
    tx_phase_d  = tx_phase_q;
    tx_shift_d  = tx_shift_q;
    tx_bit_d    = tx_bit_q;
    tx_tick_d   = tx_tick_q;
    tx_line_d   = tx_line_q;
    rx_done     = 1'b0;
    rx_tick_inc = bump(rx_tick_q);
    tx_tick_inc = bump(tx_tick_q);
    rx_bit_inc  = rx_bit_q + BITCNT_W'(1);

    if (accept) begin
      if (in_i.cmd == CMD_SEND) begin
        // send request, dropped while a frame is going out
        if (tx_phase_q == TX_IDLE) begin
          tx_phase_d = TX_START;
          tx_shift_d = in_i.send_byte;
          tx_bit_d   = '0;
          tx_tick_d  = '0;
          tx_line_d  = 1'b0;
        end
      end else begin
        // receiver: wait for low line, then sample once per bit period
        if (!rx_busy_q) begin
          if (!in_i.rx_level) begin
            rx_busy_d  = 1'b1;
            rx_shift_d = '0;
            rx_bit_d   = '0;
            rx_tick_d  = '0;
          end
        end else if (rx_tick_inc < tpb_q) begin
          rx_tick_d = rx_tick_inc;
        end else begin
          rx_tick_d  = '0;
          rx_shift_d = {in_i.rx_level, rx_shift_q[DATA_BITS-1:1]};
          if (rx_bit_inc >= DataBitsCnt) begin
            rx_busy_d = 1'b0;
            rx_bit_d  = '0;
            rx_done   = 1'b1;
          end else begin
            rx_bit_d = rx_bit_inc;
          end
        end

        // transmitter: advance one bit at the end of each bit period
        case (tx_phase_q)
          TX_IDLE: begin
            tx_line_d = 1'b1;
          end
          TX_START, TX_DATA, TX_STOP: begin
            if (tx_tick_inc < tpb_q) begin
              tx_tick_d = tx_tick_inc;
            end else begin
              tx_tick_d = '0;
              if (tx_phase_q == TX_START ||
                  (tx_phase_q == TX_DATA && tx_bit_q < DataBitsCnt)) begin
                tx_line_d  = tx_shift_q[0];
                tx_shift_d = tx_shift_q >> 1;
                tx_bit_d   = tx_bit_q + BITCNT_W'(1);
                tx_phase_d = TX_DATA;
              end else if (tx_phase_q == TX_DATA) begin
                tx_line_d  = 1'b1;
                tx_phase_d = TX_STOP;
              end else begin
                tx_line_d  = 1'b1;
                tx_phase_d = TX_IDLE;
                tx_bit_d   = '0;
              end
            end
          end
          default: begin
            tx_phase_d = TX_IDLE;
          end
        endcase
      end
    end
  end

  // Result of this item
  assign rx_ext       = {{BYTE_W{1'b0}}, rx_shift_d};
  assign res.tx_level = tx_line_d;
  assign res.tx_idle  = (tx_phase_d == TX_IDLE);
  assign res.rx_valid = rx_done;
  assign res.rx_byte  = rx_done ? rx_ext[BYTE_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_busy_q  <= 1'b0;
      rx_shift_q <= '0;
      rx_bit_q   <= '0;
      rx_tick_q  <= '0;
      tx_phase_q <= TX_IDLE;
      tx_shift_q <= '0;
      tx_bit_q   <= '0;
      tx_tick_q  <= '0;
      tx_line_q  <= 1'b1;
    end else begin
      rx_busy_q  <= rx_busy_d;
      rx_shift_q <= rx_shift_d;
      rx_bit_q   <= rx_bit_d;
      rx_tick_q  <= rx_tick_d;
      tx_phase_q <= tx_phase_d;
      tx_shift_q <= tx_shift_d;
      tx_bit_q   <= tx_bit_d;
      tx_tick_q  <= tx_tick_d;
      tx_line_q  <= tx_line_d;
    end
  end

  // Output register with skid: the output drains the skid slot first
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || out_o.ready) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = accept;
      end
    end else if (accept) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.tx_level = out_q.tx_level;
  assign out_o.tx_idle  = out_q.tx_idle;
  assign out_o.rx_valid = out_q.rx_valid;
  assign out_o.rx_byte  = out_q.rx_byte;

endmodule : tick_driven_soft_uart_core

`default_nettype wire

FILE: rtl/core/tdsu_checker.sv
// Port-level checker for the soft UART core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tdsu_checker
  import tdsu_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_i,
  input wire              out_valid_i,
  input wire              out_ready_i,
  input wire              out_tx_level_i,
  input wire              out_tx_idle_i,
  input wire              out_rx_valid_i,
  input wire [BYTE_W-1:0] out_rx_byte_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_tx_level_i, out_tx_idle_i, out_rx_valid_i, out_rx_byte_i}))
    else $error("stalled result changed");

  // input back-pressure only while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // ready drops only after a transfer into a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && out_valid_i && !out_ready_i))
    else $error("input ready fell without output stall");

  // a transfer into an empty output shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> out_valid_i)
    else $error("result lost after transfer");

  // idle transmitter rests high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_tx_idle_i |-> out_tx_level_i)
    else $error("idle transmitter drives low");

endmodule : tdsu_checker

bind tick_driven_soft_uart_core tdsu_checker u_tdsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_tx_level_i (out_o.tx_level),
  .out_tx_idle_i  (out_o.tx_idle),
  .out_rx_valid_i (out_o.rx_valid),
  .out_rx_byte_i  (out_o.rx_byte)
);

`default_nettype wire

FILE: sim/tdsu_checker.sv
// Checker for the soft UART core: predicts every result and compares it on the output channel.
`timescale 1ns / 1ps

module tdsu_scoreboard
  import tdsu_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  tdsu_in_if          in_i,
  tdsu_out_if         out_i,
  tdsu_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned NBITS      = DATA_BITS_DEFAULT;
  localparam int unsigned MAX_REPORT = 10;

  // Predicted copy of the core's registers
  logic [TICK_W-1:0]   period_q;
  logic                rx_busy_q;
  logic [BYTE_W-1:0]   rx_shift_q;
  logic [BITCNT_W-1:0] rx_bits_q;
  logic [TICK_W-1:0]   rx_ticks_q;
  tx_phase_e           tx_phase_q;
  logic [BYTE_W-1:0]   tx_shift_q;
  logic [BITCNT_W-1:0] tx_bits_q;
  logic [TICK_W-1:0]   tx_ticks_q;
  logic                tx_line_q;

  result_t     predicted_results[$];
  int unsigned mismatches;

  // Tick counters stop at all ones
  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + 1'b1;
  endfunction

  // Advance the predicted UART by one item and return the line state after it
  task automatic advance_uart(input logic cmd, input logic lvl, input logic [BYTE_W-1:0] tx_byte,
                              output result_t res);
    logic              got_valid;
    logic [BYTE_W-1:0] got_byte;
    got_valid = 1'b0;
    got_byte  = '0;
    if (cmd == CMD_SEND) begin
      // a send request is no tick; taken only while the transmitter rests
      if (tx_phase_q == TX_IDLE) begin
        tx_phase_q = TX_START;
        tx_shift_q = tx_byte;
        tx_bits_q  = '0;
        tx_ticks_q = '0;
        tx_line_q  = 1'b0;
      end
    end else begin
      // receiver
      if (!rx_busy_q) begin
        if (lvl == 1'b0) begin
          rx_busy_q  = 1'b1;
          rx_shift_q = '0;
          rx_bits_q  = '0;
          rx_ticks_q = '0;
        end
      end else begin
        rx_ticks_q = sat_inc(rx_ticks_q);
        if (rx_ticks_q >= period_q) begin
          rx_ticks_q = '0;
          rx_shift_q = {lvl, rx_shift_q[BYTE_W-1:1]};
          rx_bits_q  = rx_bits_q + 1'b1;
          if (rx_bits_q >= NBITS) begin
            rx_busy_q = 1'b0;
            rx_bits_q = '0;
            got_valid = 1'b1;
            got_byte  = rx_shift_q;
          end
        end
      end
      // transmitter
      if (tx_phase_q == TX_IDLE) begin
        tx_line_q = 1'b1;
      end else begin
        tx_ticks_q = sat_inc(tx_ticks_q);
        if (tx_ticks_q >= period_q) begin
          tx_ticks_q = '0;
          if (tx_phase_q == TX_START || (tx_phase_q == TX_DATA && tx_bits_q < NBITS)) begin
            tx_line_q  = tx_shift_q[0];
            tx_shift_q = tx_shift_q >> 1;
            tx_bits_q  = tx_bits_q + 1'b1;
            tx_phase_q = TX_DATA;
          end else if (tx_phase_q == TX_DATA) begin
            tx_line_q  = 1'b1;
            tx_phase_q = TX_STOP;
          end else begin
            tx_line_q  = 1'b1;
            tx_phase_q = TX_IDLE;
            tx_bits_q  = '0;
          end
        end
      end
    end
    res.tx_level = tx_line_q;
    res.tx_idle  = (tx_phase_q == TX_IDLE);
    res.rx_valid = got_valid;
    res.rx_byte  = got_byte;
  endtask

  // Watch the channels: results are checked before the new item is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t next_res;
    if (!rst_ni) begin
      period_q   = TICKS_PER_BIT_RESET;
      rx_busy_q  = 1'b0;
      rx_shift_q = '0;
      rx_bits_q  = '0;
      rx_ticks_q = '0;
      tx_phase_q = TX_IDLE;
      tx_shift_q = '0;
      tx_bits_q  = '0;
      tx_ticks_q = '0;
      tx_line_q  = 1'b1;
      mismatches = 0;
      predicted_results.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (predicted_results.size() == 0) begin
          if (mismatches < MAX_REPORT)
            $display("unexpected result: tx_level %0b tx_idle %0b rx_valid %0b rx_byte %02h",
                     out_i.tx_level, out_i.tx_idle, out_i.rx_valid, out_i.rx_byte);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_i.tx_level !== want.tx_level || out_i.tx_idle !== want.tx_idle ||
              out_i.rx_valid !== want.rx_valid || out_i.rx_byte !== want.rx_byte) begin
            if (mismatches < MAX_REPORT)
              $display({"mismatch (exp/got): tx_level %0b/%0b tx_idle %0b/%0b ",
                        "rx_valid %0b/%0b rx_byte %02h/%02h"},
                       want.tx_level, out_i.tx_level, want.tx_idle, out_i.tx_idle,
                       want.rx_valid, out_i.rx_valid, want.rx_byte, out_i.rx_byte);
            mismatches++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready)
        period_q = cfg_i.data;
      if (in_i.valid && in_i.ready) begin
        advance_uart(in_i.cmd, in_i.rx_level, in_i.send_byte, next_res);
        predicted_results.push_back(next_res);
      end
    end
    fail_count_o = mismatches;
    pending_o    = predicted_results.size();
  end

endmodule : tdsu_scoreboard

FILE: sim/tb_top.sv
// Testbench top for the soft UART core: clock, reset, stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tdsu_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned NPHASES     = 7;

  logic clk_i;
  logic rst_ni;

  tdsu_in_if  in_if();
  tdsu_out_if out_if();
  tdsu_cfg_if cfg_if();

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping
  int unsigned n_items;
  int unsigned phase_end;
  int unsigned bit_len;
  bit          quiet;

  tick_driven_soft_uart_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  tdsu_scoreboard i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock, 2 ns period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one item, with an optional idle burst first, and wait for its transfer
  task automatic put_item(input logic cmd, input logic lvl, input logic [BYTE_W-1:0] tx_byte);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.rx_level  <= lvl;
    in_if.send_byte <= tx_byte;
    do @(posedge clk_i); while (!in_if.ready);
    n_items++;
  endtask

  // Hold the receive line at one level for a bit period, with the odd send request
  task automatic line_bit(input logic lvl);
    int unsigned k;
    for (k = 0; k < bit_len && n_items < phase_end; k++) begin
      if ($urandom_range(0, 15) == 0)
        put_item(CMD_SEND, 1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
      put_item(CMD_TICK, lvl, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Write the bit period once the core has drained
  task automatic write_period(input logic [TICK_W-1:0] period);
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= period;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    bit_len = (period == '0) ? 1 : int'(period);
  endtask

  // Output side: random stall bursts, one long hold-off, none at the end
  initial begin : sink_ready
    int unsigned stall_left;
    bit          bursts_on;
    bit          long_hold_done;
    stall_left     = 0;
    bursts_on      = 1'b1;
    long_hold_done = 1'b0;
    out_if.ready   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0)
        bursts_on = ~bursts_on;
      if (stall_left != 0)
        stall_left--;
      else if (!long_hold_done && n_items >= 150) begin
        stall_left     = 80;
        long_hold_done = 1'b1;
      end else if (!quiet && bursts_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 10);
      out_if.ready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned       periods [NPHASES];
    int unsigned       counts  [NPHASES];
    int unsigned       p;
    int unsigned       i;
    int unsigned       k;
    int unsigned       pick;
    int unsigned       len;
    logic [BYTE_W-1:0] frame;

    periods = '{1, 2, 0, 5, 255, 3, 1};
    counts  = '{250, 250, 200, 300, 350, 200, 200};

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_TICK;
    in_if.rx_level   = 1'b1;
    in_if.send_byte  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = TICKS_PER_BIT_RESET;
    n_items          = 0;
    phase_end        = 0;
    bit_len          = 1;
    quiet            = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset bit period
    put_item(CMD_TICK, 1'b1, 8'h00);            // idle line, idle transmitter
    put_item(CMD_SEND, 1'b1, 8'hFF);            // frame starts, line drops
    put_item(CMD_SEND, 1'b0, 8'h00);            // ignored, transmitter busy
    put_item(CMD_TICK, 1'b0, 8'hFF);            // start bit on the receive line
    repeat (2) put_item(CMD_TICK, 1'b1, 8'h00);
    put_item(CMD_SEND, 1'b1, 8'h5A);            // no tick, neither side moves
    repeat (6) put_item(CMD_TICK, 1'b1, 8'h00); // 0xFF reported on the last bit
    repeat (9) put_item(CMD_TICK, 1'b0, 8'h00); // start at once, then 0x00
    put_item(CMD_SEND, 1'b0, 8'h00);            // transmitter idle again, new frame starts
    repeat (2) put_item(CMD_TICK, 1'b1, 8'hFF);

    // Random phases, one bit period each
    for (p = 0; p < NPHASES; p++) begin
      write_period(TICK_W'(periods[p]));
      quiet     = (p == NPHASES - 1);
      phase_end = n_items + counts[p];
      while (n_items < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed frame with a little idle line first
          frame = BYTE_W'($urandom_range(0, 255));
          len   = $urandom_range(0, 2);
          for (k = 0; k < len; k++) line_bit(1'b1);
          line_bit(1'b0);
          for (i = 0; i < BYTE_W; i++) line_bit(frame[i]);
          line_bit(1'b1);
        end else if (pick < 9) begin
          // noise: random commands and levels
          len = $urandom_range(1, 12);
          for (k = 0; k < len && n_items < phase_end; k++)
            put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     BYTE_W'($urandom_range(0, 255)));
        end else begin
          // broken frame cut short
          len = $urandom_range(0, 6);
          line_bit(1'b0);
          for (k = 0; k < len; k++) line_bit(1'($urandom_range(0, 1)));
        end
      end
    end

    // Drain, then let the output stages settle
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule : tb_top
